>>> sv/tft_pkg.sv
// shared types, constants and codes for the touch frame translator
package tft_pkg;

    // frame and packet geometry
    localparam int FRAME_LEN      = 4;
    localparam int OVERFLOW_LIMIT = 8;
    localparam int PACKET_LEN     = 6;

    localparam int CNT_W     = $clog2(OVERFLOW_LIMIT + 2);
    localparam int CAP_IDX_W = $clog2(FRAME_LEN);
    localparam int PKT_IDX_W = $clog2(PACKET_LEN);

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int BYTE_W   = 8;
    localparam int SCALE_W  = 10;
    localparam int PROD_W   = BYTE_W + SCALE_W;
    localparam int FRAC_W   = 8;
    localparam int TIMER_W  = 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SCALE_W;

    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_EXTENT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_TIMEOUT = 3'd4;

    localparam logic [SCALE_W-1:0] X_SCALE_RST      = 10'd486;
    localparam logic [SCALE_W-1:0] Y_SCALE_RST      = 10'd448;
    localparam logic [BYTE_W-1:0]  Y_EXTENT_RST     = 8'd94;
    localparam logic [TIMER_W-1:0] PROBE_PERIOD_RST = 8'd30;
    localparam logic [TIMER_W-1:0] INIT_TIMEOUT_RST = 8'd36;

    // screen byte codes
    localparam logic [BYTE_W-1:0] CODE_TOUCH   = 8'hFE;
    localparam logic [BYTE_W-1:0] CODE_UNTOUCH = 8'hFD;
    localparam logic [BYTE_W-1:0] CODE_REPORT  = 8'hF4;
    localparam logic [BYTE_W-1:0] CODE_END     = 8'hFF;

    // host packet bytes
    localparam logic [BYTE_W-1:0] PKT_X_HI   = 8'hC0;
    localparam logic [BYTE_W-1:0] PKT_X_LO   = 8'h80;
    localparam logic [BYTE_W-1:0] PKT_Y_HI   = 8'h40;
    localparam logic [BYTE_W-1:0] PKT_LOW6   = 8'h3F;
    localparam logic [BYTE_W-1:0] PKT_ZERO   = 8'h00;
    localparam logic [BYTE_W-1:0] PKT_Z      = 8'h15;
    localparam logic [BYTE_W-1:0] BYTE_MAX   = 8'hFF;

    // input opcodes and output kinds
    localparam logic OP_BYTE     = 1'b0;
    localparam logic OP_TICK     = 1'b1;
    localparam logic KIND_PKT    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // job codes
    localparam logic [1:0] JOB_TICK    = 2'd0;
    localparam logic [1:0] JOB_TOUCH   = 2'd1;
    localparam logic [1:0] JOB_UNTOUCH = 2'd2;
    localparam logic [1:0] JOB_RESEND  = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic [BYTE_W-1:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] tx_byte;
        logic              last;
        logic              link_ok;
        logic              init_request;
        logic              probe_request;
    } t_out;

    typedef struct packed {
        logic [SCALE_W-1:0] x_scale;
        logic [SCALE_W-1:0] y_scale;
        logic [BYTE_W-1:0]  y_extent;
        logic [TIMER_W-1:0] probe_period;
        logic [TIMER_W-1:0] init_timeout;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        op;
        logic              link_ok;
        logic              init_request;
        logic              probe_request;
        logic [BYTE_W-1:0] x_raw;
        logic [BYTE_W-1:0] y_flip;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

>>> sv/tft_front.sv
// front end: frame capture, classification, link timers, job generation
module tft_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tft_pkg::t_cfg   i_cfg,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  tft_pkg::t_in    i_in,
    input  tft_pkg::t_qstat i_qstat,
    output logic           o_push,
    output tft_pkg::t_job   o_job
);
    import tft_pkg::*;

    logic [CNT_W-1:0]   r_count, n_count;
    logic [BYTE_W-1:0]  r_cap [FRAME_LEN];
    logic [BYTE_W-1:0]  w_cap [FRAME_LEN];
    logic               r_in_frame, n_in_frame;
    logic               r_held, n_held;
    logic               r_link, n_link;
    logic               r_pend, n_pend;
    logic [TIMER_W-1:0] r_init_tmr, n_init_tmr;
    logic [TIMER_W-1:0] r_probe_tmr, n_probe_tmr;

    logic w_accept;
    logic w_capt;
    logic w_store;
    logic w_complete;
    logic w_ireq;
    logic w_preq;
    logic w_job_valid;
    logic [1:0] w_op;

    assign o_in_stall = i_qstat.full;
    assign w_accept   = i_in_valid && !i_qstat.full;

    assign w_capt  = (i_in.opcode == OP_BYTE) &&
                     (r_in_frame || i_in.rx_byte == CODE_TOUCH ||
                      i_in.rx_byte == CODE_UNTOUCH || i_in.rx_byte == CODE_REPORT);
    assign w_store = w_capt && (r_count < CNT_W'(FRAME_LEN));
    assign w_complete = w_capt && (r_count == CNT_W'(FRAME_LEN - 1)) &&
                        (i_in.rx_byte == CODE_END);

    always_comb begin
        for (int k = 0; k < FRAME_LEN; k++) begin
            w_cap[k] = (w_store && r_count[CAP_IDX_W-1:0] == CAP_IDX_W'(k)) ?
                       i_in.rx_byte : r_cap[k];
        end
    end

    always_comb begin
        n_count     = r_count;
        n_in_frame  = r_in_frame;
        n_held      = r_held;
        n_link      = r_link;
        n_pend      = r_pend;
        n_init_tmr  = r_init_tmr;
        n_probe_tmr = r_probe_tmr;
        w_ireq      = 1'b0;
        w_preq      = 1'b0;
        w_job_valid = 1'b0;
        w_op        = JOB_TICK;

        if (i_in.opcode == OP_TICK) begin
            w_job_valid = 1'b1;
            w_op        = JOB_TICK;
            if (!r_link) begin
                n_init_tmr = r_init_tmr + 1'b1;
                if (r_init_tmr > i_cfg.init_timeout) begin
                    n_init_tmr = '0;
                    w_ireq     = 1'b1;
                end
            end
            n_probe_tmr = r_probe_tmr + 1'b1;
            if (r_probe_tmr > i_cfg.probe_period && !r_in_frame) begin
                n_probe_tmr = '0;
                n_link      = 1'b0;
                w_preq      = 1'b1;
            end
            // a pending init request is handed off by this status beat
            w_ireq = w_ireq || r_pend;
            n_pend = 1'b0;
        end else begin
            if (w_capt) begin
                n_in_frame = 1'b1;
                n_count    = r_count + 1'b1;
            end
            if (w_complete) begin
                n_count    = '0;
                n_in_frame = 1'b0;
                case (w_cap[0])
                    CODE_TOUCH: begin
                        n_held      = 1'b1;
                        w_job_valid = 1'b1;
                        w_op        = JOB_TOUCH;
                    end
                    CODE_UNTOUCH: begin
                        n_held      = 1'b0;
                        w_job_valid = 1'b1;
                        w_op        = JOB_UNTOUCH;
                    end
                    CODE_REPORT: begin
                        if (r_held) begin
                            w_job_valid = 1'b1;
                            w_op        = JOB_RESEND;
                        end else begin
                            n_link     = 1'b1;
                            n_pend     = 1'b0;
                            n_init_tmr = '0;
                        end
                    end
                    default: begin
                        w_job_valid = r_held;
                        w_op        = JOB_RESEND;
                    end
                endcase
            end
            // frame never closed
            if (n_count > CNT_W'(OVERFLOW_LIMIT)) begin
                n_count    = '0;
                n_in_frame = 1'b0;
                n_held     = 1'b0;
            end
        end
    end

    assign o_push = w_accept && w_job_valid;

    always_comb begin
        o_job.op            = w_op;
        o_job.link_ok       = n_link;
        o_job.init_request  = w_ireq;
        o_job.probe_request = w_preq;
        o_job.x_raw         = w_cap[1];
        o_job.y_flip        = i_cfg.y_extent - w_cap[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_in_frame  <= 1'b0;
            r_held      <= 1'b0;
            r_link      <= 1'b0;
            r_pend      <= 1'b0;
            r_init_tmr  <= '0;
            r_probe_tmr <= '0;
        end else if (w_accept) begin
            r_count     <= n_count;
            r_in_frame  <= n_in_frame;
            r_held      <= n_held;
            r_link      <= n_link;
            r_pend      <= n_pend;
            r_init_tmr  <= n_init_tmr;
            r_probe_tmr <= n_probe_tmr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cap <= w_cap;
        end
    end

endmodule

>>> sv/tft_queue.sv
// short job queue between the front and back ends
module tft_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tft_pkg::t_job    i_job,
    input  logic            i_pop,
    output tft_pkg::t_job    o_job,
    output tft_pkg::t_qstat  o_stat
);
    import tft_pkg::*;

    t_job              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        r = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    assign o_job        = r_q[r_rd];
    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_job;
        end
    end

endmodule

>>> sv/tft_back.sv
// back end: scaling, host packet build and byte serializer
module tft_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tft_pkg::t_cfg    i_cfg,
    input  tft_pkg::t_job    i_job,
    input  tft_pkg::t_qstat  i_qstat,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output tft_pkg::t_out    o_out
);
    import tft_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]           r_st, n_st;
    logic [PKT_IDX_W-1:0] r_idx, n_idx;
    logic                 r_ov, n_ov;
    t_out                 r_out, n_out;
    logic                 r_link, n_link;
    logic [BYTE_W-1:0]    r_pkt [PACKET_LEN];
    logic [BYTE_W-1:0]    n_pkt [PACKET_LEN];
    logic [PROD_W-1:0]    r_px, n_px;
    logic [PROD_W-1:0]    r_py, n_py;

    logic              w_out_free;
    logic [BYTE_W-1:0] w_x, w_y;

    // truncate the Q10.8 product of a byte and a Q2.8 scale and clamp to one byte
    assign w_x = (r_px[PROD_W-1:FRAC_W+BYTE_W] != '0) ? BYTE_MAX :
                 r_px[FRAC_W+BYTE_W-1:FRAC_W];
    assign w_y = (r_py[PROD_W-1:FRAC_W+BYTE_W] != '0) ? BYTE_MAX :
                 r_py[FRAC_W+BYTE_W-1:FRAC_W];

    assign w_out_free = !r_ov || !i_out_stall;

    always_comb begin
        n_st   = r_st;
        n_idx  = r_idx;
        n_ov   = r_ov;
        n_out  = r_out;
        n_link = r_link;
        n_pkt  = r_pkt;
        n_px   = r_px;
        n_py   = r_py;
        o_pop  = 1'b0;

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        case (r_st)
            ST_IDLE: begin
                if (!i_qstat.empty) begin
                    n_link = i_job.link_ok;
                    n_idx  = '0;
                    case (i_job.op)
                        JOB_TICK: begin
                            if (w_out_free) begin
                                o_pop               = 1'b1;
                                n_ov                = 1'b1;
                                n_out.kind          = KIND_STATUS;
                                n_out.tx_byte       = PKT_ZERO;
                                n_out.last          = 1'b1;
                                n_out.link_ok       = i_job.link_ok;
                                n_out.init_request  = i_job.init_request;
                                n_out.probe_request = i_job.probe_request;
                            end
                        end
                        JOB_TOUCH: begin
                            o_pop = 1'b1;
                            n_px  = PROD_W'(i_job.x_raw) * PROD_W'(i_cfg.x_scale);
                            n_py  = PROD_W'(i_job.y_flip) * PROD_W'(i_cfg.y_scale);
                            n_st  = ST_CALC;
                        end
                        JOB_UNTOUCH: begin
                            o_pop    = 1'b1;
                            n_pkt[0] = PKT_X_HI;
                            n_pkt[1] = PKT_X_LO;
                            n_pkt[2] = PKT_Y_HI;
                            n_pkt[3] = PKT_ZERO;
                            n_pkt[4] = PKT_ZERO;
                            n_pkt[5] = PKT_ZERO;
                            n_st     = ST_EMIT;
                        end
                        default: begin
                            // held touch: resend stored packet
                            o_pop = 1'b1;
                            n_st  = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_CALC: begin
                n_pkt[0] = PKT_X_HI | {6'b0, w_x[7:6]};
                n_pkt[1] = PKT_X_LO | (w_x & PKT_LOW6);
                n_pkt[2] = PKT_Y_HI | {6'b0, w_y[7:6]};
                n_pkt[3] = w_y & PKT_LOW6;
                n_pkt[4] = PKT_ZERO;
                n_pkt[5] = PKT_Z;
                n_st     = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_ov                = 1'b1;
                    n_out.kind          = KIND_PKT;
                    n_out.tx_byte       = r_pkt[r_idx];
                    n_out.last          = (r_idx == PKT_IDX_W'(PACKET_LEN - 1));
                    n_out.link_ok       = r_link;
                    n_out.init_request  = 1'b0;
                    n_out.probe_request = 1'b0;
                    if (r_idx == PKT_IDX_W'(PACKET_LEN - 1)) begin
                        n_st = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_idx <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_idx <= n_idx;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_link <= n_link;
        r_pkt  <= n_pkt;
        r_px   <= n_px;
        r_py   <= n_py;
    end

endmodule

>>> sv/touch_frame_translator_top.sv
// top level of the touch frame translator: config registers, front, queue, back
//
// Input channel (i_in_valid / o_in_stall / i_in): one beat is either a byte
// from the touchscreen controller or a one-second tick. The front end takes a
// beat in every cycle unless its four-entry job queue is full.
// Output channel (o_out_valid / i_out_stall / o_out): a tick gives one status
// beat; a completed touch, untouch or held-touch frame gives six packet beats,
// the sixth marked last.
// Path: a tick status beat passes the queue and the output register. A resend
// or untouch packet's first byte passes the queue, the packet registers and the
// output register; a touch packet's first byte also passes the product registers.
// The serializer then sends one byte per cycle unless the receiver stalls; the
// back end takes the next job only after the last byte of a packet.
// When the receiver stalls, the output register holds its beat; jobs gather in
// the queue and the input stalls only once the queue is full.
// Configuration writes (i_cfg_we) take effect at once and are expected only
// while the block is idle.
// Reset (i_rst_n low, synchronous) clears the capture, hold, link and timer
// state, empties the queue and loads the configuration defaults.
module touch_frame_translator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  tft_pkg::t_in                       i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output tft_pkg::t_out                      o_out,
    input  logic                              i_cfg_we,
    input  logic [tft_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tft_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tft_pkg::*;

    t_cfg   r_cfg;
    t_job   w_push_job, w_head_job;
    t_qstat w_qstat;
    logic   w_push, w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_scale      <= X_SCALE_RST;
            r_cfg.y_scale      <= Y_SCALE_RST;
            r_cfg.y_extent     <= Y_EXTENT_RST;
            r_cfg.probe_period <= PROBE_PERIOD_RST;
            r_cfg.init_timeout <= INIT_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_X_SCALE:      r_cfg.x_scale      <= i_cfg_data;
                REG_Y_SCALE:      r_cfg.y_scale      <= i_cfg_data;
                REG_Y_EXTENT:     r_cfg.y_extent     <= i_cfg_data[BYTE_W-1:0];
                REG_PROBE_PERIOD: r_cfg.probe_period <= i_cfg_data[TIMER_W-1:0];
                REG_INIT_TIMEOUT: r_cfg.init_timeout <= i_cfg_data[TIMER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tft_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_qstat    (w_qstat),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    tft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_stat  (w_qstat)
    );

    tft_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (w_head_job),
        .i_qstat     (w_qstat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("job popped from empty queue");

    a_pkt_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.kind == KIND_PKT) |->
            (!o_out.init_request && !o_out.probe_request))
        else $error("packet beat carries status flags");
`endif

endmodule

>>> tb/sv/touch_frame_translator_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the touch frame translator: frames, ticks, timeouts, stalls
module touch_frame_translator_top_tb;
    import tft_pkg::*;

    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 38;
    localparam int HOLD_CYCLES   = 120;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 10;
    localparam int TIMEOUT_NS    = 2_000_000;

    class frame_scoreboard;
        t_cfg               cfg;
        int unsigned        cap_count;
        logic [BYTE_W-1:0]  cap_bytes [FRAME_LEN];
        bit                 in_frame, touch_held, link_good, init_pending;
        logic [BYTE_W-1:0]  packet [PACKET_LEN];
        logic [TIMER_W-1:0] init_timer, probe_timer;
        t_out               expected_beats [$];
        int unsigned        errors, compared;
        int unsigned        n_touch, n_untouch, n_report, n_tick, n_overflow, n_probe, n_init;

        function new();
            cfg.x_scale      = X_SCALE_RST;
            cfg.y_scale      = Y_SCALE_RST;
            cfg.y_extent     = Y_EXTENT_RST;
            cfg.probe_period = PROBE_PERIOD_RST;
            cfg.init_timeout = INIT_TIMEOUT_RST;
            cap_count    = 0;
            in_frame     = 0;
            touch_held   = 0;
            link_good    = 0;
            init_pending = 0;
            init_timer   = '0;
            probe_timer  = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_X_SCALE:      cfg.x_scale      = val;
                REG_Y_SCALE:      cfg.y_scale      = val;
                REG_Y_EXTENT:     cfg.y_extent     = val[BYTE_W-1:0];
                REG_PROBE_PERIOD: cfg.probe_period = val[TIMER_W-1:0];
                REG_INIT_TIMEOUT: cfg.init_timeout = val[TIMER_W-1:0];
                default: ;
            endcase
        endfunction

        // unsigned product with a q2.8 scale, truncated and clipped to one byte
        function logic [BYTE_W-1:0] q28_scale(logic [BYTE_W-1:0] v, logic [SCALE_W-1:0] s);
            logic [PROD_W-1:0] prod;
            prod = PROD_W'(v) * PROD_W'(s);
            if (prod[PROD_W-1:FRAC_W+BYTE_W] != '0) return BYTE_MAX;
            return prod[FRAC_W+BYTE_W-1:FRAC_W];
        endfunction

        function void push_beat(logic kind, logic [BYTE_W-1:0] data, logic last,
                                logic ireq, logic preq);
            t_out r;
            r.kind          = kind;
            r.tx_byte       = data;
            r.last          = last;
            r.link_ok       = link_good;
            r.init_request  = ireq;
            r.probe_request = preq;
            expected_beats.push_back(r);
        endfunction

        function void predict_tick();
            logic               preq, ireq;
            logic [TIMER_W-1:0] prev;
            preq = 1'b0;
            if (!link_good) begin
                prev = init_timer;
                init_timer = init_timer + 1'b1;
                if (prev > cfg.init_timeout) begin
                    init_timer   = '0;
                    init_pending = 1;
                end
            end
            prev = probe_timer;
            probe_timer = probe_timer + 1'b1;
            // no probe while a frame is being captured
            if (prev > cfg.probe_period && !in_frame) begin
                probe_timer = '0;
                link_good   = 0;
                preq        = 1'b1;
            end
            ireq = init_pending;
            init_pending = 0;
            n_tick++;
            n_probe += preq;
            n_init  += ireq;
            push_beat(KIND_STATUS, PKT_ZERO, 1'b1, ireq, preq);
        endfunction

        function void predict_byte(logic [BYTE_W-1:0] b);
            logic [BYTE_W-1:0] head, xv, yv, yf;
            bit                drop_hold;
            if (in_frame || b == CODE_TOUCH || b == CODE_UNTOUCH || b == CODE_REPORT) begin
                in_frame = 1;
                if (cap_count < FRAME_LEN) cap_bytes[cap_count[CAP_IDX_W-1:0]] = b;
                cap_count++;
            end
            if (cap_count == FRAME_LEN && cap_bytes[FRAME_LEN-1] == CODE_END) begin
                head      = cap_bytes[0];
                drop_hold = 0;
                cap_count = 0;
                in_frame  = 0;
                if (head == CODE_TOUCH) begin
                    xv = q28_scale(cap_bytes[1], cfg.x_scale);
                    yf = cfg.y_extent - cap_bytes[2];
                    yv = q28_scale(yf, cfg.y_scale);
                    touch_held = 1;
                    // coordinates split into top two bits and low six bits
                    packet[0] = PKT_X_HI | (xv >> 6);
                    packet[1] = PKT_X_LO | (xv & PKT_LOW6);
                    packet[2] = PKT_Y_HI | (yv >> 6);
                    packet[3] = yv & PKT_LOW6;
                    packet[4] = PKT_ZERO;
                    packet[5] = PKT_Z;
                    n_touch++;
                end
                if (head == CODE_UNTOUCH) begin
                    drop_hold = 1;
                    packet = '{PKT_X_HI, PKT_X_LO, PKT_Y_HI, PKT_ZERO, PKT_ZERO, PKT_ZERO};
                    n_untouch++;
                end
                if (!touch_held && !drop_hold && head == CODE_REPORT) begin
                    link_good    = 1;
                    init_pending = 0;
                    init_timer   = '0;
                    n_report++;
                end
                if (touch_held || drop_hold) begin
                    for (int k = 0; k < PACKET_LEN; k++)
                        push_beat(KIND_PKT, packet[k], k == PACKET_LEN - 1, 1'b0, 1'b0);
                end
                if (drop_hold) touch_held = 0;
            end
            if (cap_count > OVERFLOW_LIMIT) begin
                cap_count  = 0;
                in_frame   = 0;
                touch_held = 0;
                n_overflow++;
            end
        endfunction

        function void note_screen_beat(t_in b);
            if (b.opcode == OP_TICK) predict_tick();
            else predict_byte(b.rx_byte);
        endfunction

        function string show(t_out v);
            return $sformatf("kind=%0b byte=%h last=%0b link=%0b init=%0b probe=%0b",
                             v.kind, v.tx_byte, v.last, v.link_ok, v.init_request,
                             v.probe_request);
        endfunction

        function void check_host_beat(t_out got);
            t_out want;
            compared++;
            if (expected_beats.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected output beat: %s", $time, show(got));
                return;
            end
            want = expected_beats.pop_front();
            if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
                got.last !== want.last || got.link_ok !== want.link_ok ||
                got.init_request !== want.init_request ||
                got.probe_request !== want.probe_request) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: output beat %0d wrong", $time, compared);
                    $display("    expected %s", show(want));
                    $display("    actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in                   i_in;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out                  o_out;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    frame_scoreboard sb;
    int              burst_left;
    int              phase_items;
    int              settings_used;
    bit              hold_req;

    touch_frame_translator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d beats outstanding", sb.expected_beats.size());
        $display("Mismatches found");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_host_beat(o_out);
    end

    // receiver back-pressure: random stretches, plus one long hold-off on request
    initial begin : out_stall_gen
        int run_mode, run_left, hold_left;
        i_out_stall = 1'b0;
        run_mode    = 0;
        run_left    = 0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall = 1'b1;
            end else if (hold_req) begin
                hold_req    = 0;
                hold_left   = HOLD_CYCLES - 1;
                i_out_stall = 1'b1;
            end else begin
                if (run_left == 0) begin
                    run_mode = $urandom_range(0, 3);
                    run_left = $urandom_range(4, 40);
                end
                run_left--;
                case (run_mode)
                    0: i_out_stall = 1'b0;
                    1: i_out_stall = ($urandom_range(0, 3) == 0);
                    2: i_out_stall = ($urandom_range(0, 1) == 1);
                    default: i_out_stall = ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic put_beat(t_in b, bit counted);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in       = b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_screen_beat(b);
        burst_left--;
        if (counted) phase_items++;
    endtask

    task automatic put_byte(logic [BYTE_W-1:0] v, bit counted = 1'b1);
        t_in b;
        b.opcode  = OP_BYTE;
        b.rx_byte = v;
        put_beat(b, counted);
    endtask

    task automatic put_tick();
        t_in b;
        b.opcode  = OP_TICK;
        b.rx_byte = BYTE_W'($urandom_range(0, 255));
        put_beat(b, 1'b1);
    endtask

    function automatic logic [BYTE_W-1:0] data_byte();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? BYTE_MAX : PKT_ZERO;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [BYTE_W-1:0] start_code();
        case ($urandom_range(0, 2))
            0: return CODE_TOUCH;
            1: return CODE_UNTOUCH;
            default: return CODE_REPORT;
        endcase
    endfunction

    // well-formed frame, now and then with a tick in the middle of the capture
    task automatic put_frame(logic [BYTE_W-1:0] head);
        int tick_at;
        tick_at = ($urandom_range(0, 6) == 0) ? $urandom_range(1, FRAME_LEN - 1) : 0;
        put_byte(head);
        for (int i = 1; i < FRAME_LEN; i++) begin
            if (i == tick_at) put_tick();
            put_byte(i == FRAME_LEN - 1 ? CODE_END : data_byte());
        end
    endtask

    task automatic random_sequence();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 30) put_frame(CODE_TOUCH);
        else if (pick < 44) put_frame(CODE_UNTOUCH);
        else if (pick < 54) put_frame(CODE_REPORT);
        else if (pick < 74) put_tick();
        else if (pick < 82) put_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
        else if (pick < 91) begin
            put_byte(start_code());
            n = $urandom_range(1, OVERFLOW_LIMIT);
            repeat (n) put_byte(BYTE_W'($urandom_range(0, 255)));
        end else begin
            // capture that never sees its end mark
            put_byte(start_code());
            repeat (OVERFLOW_LIMIT) put_byte(BYTE_W'($urandom_range(0, 254)));
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        burst_left = 0;
        while (sb.expected_beats.size() != 0) @(posedge i_clk);
        // frames with no output may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic apply_setting(logic [SCALE_W-1:0] xs, logic [SCALE_W-1:0] ys,
                                 logic [BYTE_W-1:0] ye, logic [TIMER_W-1:0] pp,
                                 logic [TIMER_W-1:0] it);
        write_reg(REG_X_SCALE, xs);
        write_reg(REG_Y_SCALE, ys);
        write_reg(REG_Y_EXTENT, CFG_DATA_W'(ye));
        write_reg(REG_PROBE_PERIOD, CFG_DATA_W'(pp));
        write_reg(REG_INIT_TIMEOUT, CFG_DATA_W'(it));
        settings_used++;
    endtask

    initial begin : main_flow
        int leftover;
        sb            = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in          = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        hold_req      = 0;
        burst_left    = 0;
        phase_items   = 0;
        settings_used = 1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: tick, stray end mark, report, touch at the extremes,
        // report under a held touch, overflow dropping the hold, untouch
        put_tick();
        put_byte(CODE_END, 1'b0);
        put_byte(CODE_REPORT); put_byte(8'h00); put_byte(8'h00); put_byte(CODE_END);
        put_byte(CODE_TOUCH); put_byte(BYTE_MAX); put_byte(8'h00); put_byte(CODE_END);
        put_byte(CODE_REPORT); put_byte(8'h55); put_byte(8'hAA); put_byte(CODE_END);
        put_byte(CODE_TOUCH);
        repeat (OVERFLOW_LIMIT) put_byte(8'h7F);
        put_byte(CODE_UNTOUCH); put_byte(8'h00); put_byte(BYTE_MAX); put_byte(CODE_END);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: apply_setting(10'd1023, 10'd1023, 8'd255, 8'd0, 8'd0);
                1: apply_setting(10'd0, 10'd0, 8'd0, 8'd255, 8'd255);
                default: apply_setting(SCALE_W'($urandom_range(0, 1023)),
                                       SCALE_W'($urandom_range(0, 1023)),
                                       BYTE_W'($urandom_range(0, 255)),
                                       TIMER_W'($urandom_range(0, 12)),
                                       TIMER_W'($urandom_range(0, 12)));
            endcase
            phase_items = 0;
            if (p == 2) begin
                // receiver holds off while touches keep coming, so the input backs up
                hold_req = 1;
                repeat (6) put_frame(CODE_TOUCH);
            end
            while (phase_items < PHASE_ITEMS) random_sequence();
            settle();
        end

        leftover = sb.expected_beats.size();
        if (leftover != 0) begin
            sb.errors += leftover;
            $display("%0d expected output beats never arrived", leftover);
        end
        $display("run covered %0d touch, %0d untouch, %0d link report frames, %0d ticks, %0d overruns",
                 sb.n_touch, sb.n_untouch, sb.n_report, sb.n_tick, sb.n_overflow);
        $display("%0d output beats compared over %0d register settings, %0d probes, %0d re-inits",
                 sb.compared, settings_used, sb.n_probe, sb.n_init);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
